>>> src/md5c_pkg.sv
`default_nettype none

package md5c_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NUM_WORDS = 16;
    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned IDX_W = $clog2(NUM_WORDS);
    localparam int unsigned ROUND_W = $clog2(NUM_ROUNDS);
    localparam int unsigned PC_W = 3;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [ROUND_W-1:0] round_t;
    typedef logic [PC_W-1:0] pc_t;

    localparam word_t INIT_A = 32'h67452301;
    localparam word_t INIT_B = 32'hefcdab89;
    localparam word_t INIT_C = 32'h98badcfe;
    localparam word_t INIT_D = 32'h10325476;

    localparam idx_t LAST_IDX = idx_t'(NUM_WORDS - 1);
    localparam round_t LAST_ROUND = round_t'(NUM_ROUNDS - 1);

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_ROUND,
        OP_FINAL
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_BLOCK,
        COND_MORE_ROUNDS,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    localparam pc_t PC_IDLE  = 3'd0;
    localparam pc_t PC_LOAD  = 3'd1;
    localparam pc_t PC_ROUND = 3'd2;
    localparam pc_t PC_WAIT  = 3'd3;
    localparam pc_t PC_FINAL = 3'd4;

    // control store: collect block, load working words, 64 rounds, wait for
    // output register, fold into chaining words
    function automatic ctrl_t program_word(input pc_t pc);
        ctrl_t cw;
        case (pc)
            PC_IDLE:  cw = '{op: OP_NOP,   cond: COND_NO_BLOCK,    target: PC_IDLE};
            PC_LOAD:  cw = '{op: OP_LOAD,  cond: COND_NEVER,       target: PC_IDLE};
            PC_ROUND: cw = '{op: OP_ROUND, cond: COND_MORE_ROUNDS, target: PC_ROUND};
            PC_WAIT:  cw = '{op: OP_NOP,   cond: COND_OUT_BUSY,    target: PC_WAIT};
            PC_FINAL: cw = '{op: OP_FINAL, cond: COND_ALWAYS,      target: PC_IDLE};
            default:  cw = '{op: OP_NOP,   cond: COND_ALWAYS,      target: PC_IDLE};
        endcase
        return cw;
    endfunction

    localparam word_t SINE_K [NUM_ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMOUNT [4][4] = '{
        '{5'd7, 5'd12, 5'd17, 5'd22},
        '{5'd5, 5'd9,  5'd14, 5'd20},
        '{5'd4, 5'd11, 5'd16, 5'd23},
        '{5'd6, 5'd10, 5'd15, 5'd21}
    };

    function automatic idx_t word_index(input round_t r);
        idx_t low;
        idx_t g;
        low = r[IDX_W-1:0];
        case (r[ROUND_W-1:IDX_W])
            2'd0:    g = low;
            2'd1:    g = idx_t'(low * 4'd5 + 4'd1);
            2'd2:    g = idx_t'(low * 4'd3 + 4'd5);
            default: g = idx_t'(low * 4'd7);
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

>>> src/md5c_round.sv
`default_nettype none

module md5c_round
    import md5c_pkg::*;
(
    input  wire word_t  a,
    input  wire word_t  b,
    input  wire word_t  c,
    input  wire word_t  d,
    input  wire word_t  w,
    input  wire round_t round,
    output word_t       new_b
);

    logic [1:0]        phase;
    word_t             f;
    word_t             t;
    logic [4:0]        s;
    logic [2*WORD_W-1:0] dbl;

    always_comb
    begin
        phase = round[ROUND_W-1:IDX_W];
        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        t = a + f + w + SINE_K[round];
        s = ROT_AMOUNT[phase][round[1:0]];
        dbl = {t, t} << s;
        new_b = b + dbl[2*WORD_W-1:WORD_W];
    end

endmodule

`default_nettype wire

>>> src/md5_block_compression.sv
`default_nettype none

// md5 block compression engine
// word channel: message_word / new_message with word_valid, word_stall.
//   sixteen items make one 512-bit block; new_message on an item reloads the
//   standard initial chaining words and makes that item word 0 of a block
// digest channel: digest_a..digest_d with digest_valid, digest_stall; one
//   item per block, the chaining words after that block
// sequence: after the sixteenth word is taken come one load step, 64
//   rounds at one round per cycle in the round unit, one wait step and
//   one final add step
// block rate: words of the next block are taken only after the final add,
//   so it is set by the single shared round unit stepping through the 64 rounds
// word_stall is high while a block is being compressed; words of the next
//   block are taken while a digest still waits in the output register
// if the receiver stalls the digest, it holds and the next compression
//   waits before its final add until the digest has been taken
// reset: chaining words return to the initial values, the word count and
//   sequencer clear and no digest is pending

module md5_block_compression
    import md5c_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire  [31:0] message_word,
    input  wire         new_message,
    input  wire         word_valid,
    output logic        word_stall,
    output logic [31:0] digest_a,
    output logic [31:0] digest_b,
    output logic [31:0] digest_c,
    output logic [31:0] digest_d,
    output logic        digest_valid,
    input  wire         digest_stall
);

    pc_t    pc_reg, pc_next;
    idx_t   word_count_reg, word_count_next;
    round_t round_reg, round_next;
    logic   digest_valid_reg, digest_valid_next;
    word_t  chain_reg [4];
    word_t  chain_next [4];
    word_t  a_reg, b_reg, c_reg, d_reg;
    word_t  block_mem [NUM_WORDS];
    word_t  mem_rd_reg;
    idx_t   rd_addr;
    idx_t   wr_addr;
    ctrl_t  ctrl;
    logic   word_accept;
    logic   last_word;
    logic   cond_true;
    word_t  new_b;

    md5c_round u_round (
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .w     (mem_rd_reg),
        .round (round_reg),
        .new_b (new_b)
    );

    always_comb
    begin
        ctrl = program_word(pc_reg);
        word_stall = (pc_reg != PC_IDLE);
        word_accept = word_valid && !word_stall;
        wr_addr = new_message ? '0 : word_count_reg;
        last_word = word_accept && (wr_addr == LAST_IDX);

        case (ctrl.cond)
            COND_NEVER:       cond_true = 1'b0;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_NO_BLOCK:    cond_true = !last_word;
            COND_MORE_ROUNDS: cond_true = (round_reg != LAST_ROUND);
            COND_OUT_BUSY:    cond_true = digest_valid_reg;
            default:          cond_true = 1'b1;
        endcase
        pc_next = cond_true ? ctrl.target : pc_t'(pc_reg + 1'b1);

        word_count_next = word_count_reg;
        if (word_accept)
        begin
            word_count_next = (wr_addr == LAST_IDX) ? '0 : idx_t'(wr_addr + 1'b1);
        end

        round_next = round_reg;
        rd_addr = word_index(round_reg);
        case (ctrl.op)
            OP_LOAD:
            begin
                round_next = '0;
                rd_addr = word_index('0);
            end
            OP_ROUND:
            begin
                round_next = round_t'(round_reg + 1'b1);
                rd_addr = word_index(round_t'(round_reg + 1'b1));
            end
            default:
            begin
                round_next = round_reg;
            end
        endcase

        for (int i = 0; i < 4; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        if (word_accept && new_message)
        begin
            chain_next[0] = INIT_A;
            chain_next[1] = INIT_B;
            chain_next[2] = INIT_C;
            chain_next[3] = INIT_D;
        end
        else if (ctrl.op == OP_FINAL)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
        end

        digest_valid_next = digest_valid_reg;
        if (ctrl.op == OP_FINAL)
        begin
            digest_valid_next = 1'b1;
        end
        else if (digest_valid_reg && !digest_stall)
        begin
            digest_valid_next = 1'b0;
        end

        digest_valid = digest_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
            word_count_reg <= '0;
            round_reg <= '0;
            digest_valid_reg <= 1'b0;
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end
        else
        begin
            pc_reg <= pc_next;
            word_count_reg <= word_count_next;
            round_reg <= round_next;
            digest_valid_reg <= digest_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // block word store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (word_accept)
        begin
            block_mem[wr_addr] <= message_word;
        end
        mem_rd_reg <= block_mem[rd_addr];
    end

    // working words and digest payload
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD:
            begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
            end
            OP_ROUND:
            begin
                a_reg <= d_reg;
                b_reg <= new_b;
                c_reg <= b_reg;
                d_reg <= c_reg;
            end
            OP_FINAL:
            begin
                digest_a <= chain_next[0];
                digest_b <= chain_next[1];
                digest_c <= chain_next[2];
                digest_d <= chain_next[3];
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_ROUND && pc_next != PC_ROUND) |-> round_reg == LAST_ROUND)
        else $error("round loop left early");

    a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> $past(pc_reg) == PC_FINAL)
        else $error("digest raised outside final step");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_LOAD) |-> word_count_reg == '0)
        else $error("word count not cleared at block start");

    a_final_free: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_FINAL) |-> !digest_valid_reg)
        else $error("final add over a pending digest");
`endif

endmodule

`default_nettype wire
